FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, masked while reset is high
`define RCSP_ASSERT_SYNC(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset
`define RCSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/rcsp_pkg.sv
// ----------------------------------------------------------------------------
// rcsp_pkg
// Types and constants of the reference counted slot pool.
// ----------------------------------------------------------------------------
package rcsp_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_BITS  = 4;
   localparam int COUNT_BITS = 8;
   localparam int FRAME_BITS = 32;
   localparam int OP_BITS    = 3;
   localparam int ST_BITS    = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [OP_BITS-1:0] {
      OP_NEW           = 3'd0,
      OP_ACQUIRE       = 3'd1,
      OP_ACQUIRE_LATEST = 3'd2,
      OP_SET_LATEST    = 3'd3,
      OP_RELEASE       = 3'd4
   } op_type;

   typedef enum logic [ST_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_NO_LATEST = 3'd4,
      ST_DUPLICATE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture request, run tag compare
      logic exec;   // update pool, load response register
   } cmd_type;

endpackage

FILE: sv/rcsp_if.sv
// ----------------------------------------------------------------------------
// rcsp request and response channels
// Valid/ready channels carrying the pool request and its response.
// ----------------------------------------------------------------------------
interface rcsp_req_if;
   logic                             valid;
   logic                             ready;
   logic [rcsp_pkg::OP_BITS-1:0]     op;
   logic [rcsp_pkg::FRAME_BITS-1:0]  frame_index;

   modport source (output valid, output op, output frame_index, input ready);
   modport sink   (input valid, input op, input frame_index, output ready);
endinterface

interface rcsp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rcsp_pkg::ST_BITS-1:0]     status;
   logic [rcsp_pkg::SLOT_BITS-1:0]   slot;
   logic [rcsp_pkg::FRAME_BITS-1:0]  frame_out;
   logic [rcsp_pkg::COUNT_BITS-1:0]  use_count;
   logic                             slot_freed;

   modport source (output valid, output status, output slot, output frame_out,
                   output use_count, output slot_freed, input ready);
   modport sink   (input valid, input status, input slot, input frame_out,
                   input use_count, input slot_freed, output ready);
endinterface

FILE: sv/rcsp_ctrl.sv
// ----------------------------------------------------------------------------
// rcsp_ctrl
// Sequencer: accept a request, execute it, hold the response until taken.
// ----------------------------------------------------------------------------
module rcsp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rcsp_pkg::cmd_type cmd
);

   rcsp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcsp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rcsp_pkg::S_IDLE: begin
            if (req_valid) state_in = rcsp_pkg::S_EXEC;
         end
         rcsp_pkg::S_EXEC: begin
            state_in = rcsp_pkg::S_RESP;
         end
         rcsp_pkg::S_RESP: begin
            // next request may enter as the response leaves
            if (rsp_ready) state_in = req_valid ? rcsp_pkg::S_EXEC : rcsp_pkg::S_IDLE;
         end
         default: begin
            state_in = rcsp_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.exec  = 1'b0;
      unique case (state_ff)
         rcsp_pkg::S_IDLE: begin
            req_ready = 1'b1;
         end
         rcsp_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
         end
         rcsp_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.load = req_valid & req_ready;
   end

endmodule

FILE: sv/rcsp_datapath.sv
// ----------------------------------------------------------------------------
// rcsp_datapath
// Slot tables, tag compare, count update and response register.
// ----------------------------------------------------------------------------
module rcsp_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  rcsp_pkg::cmd_type                cmd,
   input  logic [rcsp_pkg::OP_BITS-1:0]     req_op,
   input  logic [rcsp_pkg::FRAME_BITS-1:0]  req_frame_index,
   output logic [rcsp_pkg::ST_BITS-1:0]     rsp_status,
   output logic [rcsp_pkg::SLOT_BITS-1:0]   rsp_slot,
   output logic [rcsp_pkg::FRAME_BITS-1:0]  rsp_frame_out,
   output logic [rcsp_pkg::COUNT_BITS-1:0]  rsp_use_count,
   output logic                             rsp_slot_freed
);

   // pool state
   logic [rcsp_pkg::SLOTS-1:0]      busy_ff, busy_in;
   logic [rcsp_pkg::COUNT_BITS-1:0] count_ff [rcsp_pkg::SLOTS];
   logic [rcsp_pkg::COUNT_BITS-1:0] count_in [rcsp_pkg::SLOTS];
   logic [rcsp_pkg::FRAME_BITS-1:0] frame_ff [rcsp_pkg::SLOTS];
   logic                            latest_valid_ff, latest_valid_in;
   logic [rcsp_pkg::SLOT_BITS-1:0]  latest_slot_ff, latest_slot_in;

   // captured request
   logic [rcsp_pkg::OP_BITS-1:0]    op_ff;
   logic [rcsp_pkg::FRAME_BITS-1:0] fr_ff;
   logic [rcsp_pkg::SLOTS-1:0]      match_ff, match_in;
   logic [rcsp_pkg::COUNT_BITS-1:0] lat_count_ff;

   // response register
   logic [rcsp_pkg::ST_BITS-1:0]    status_ff;
   logic [rcsp_pkg::SLOT_BITS-1:0]  slot_ff;
   logic [rcsp_pkg::FRAME_BITS-1:0] frame_out_ff;
   logic [rcsp_pkg::COUNT_BITS-1:0] use_count_ff;
   logic                            freed_ff;

   rcsp_pkg::status_type            status_in;
   logic [rcsp_pkg::SLOT_BITS-1:0]  slot_in;
   logic [rcsp_pkg::FRAME_BITS-1:0] frame_out_in;
   logic [rcsp_pkg::COUNT_BITS-1:0] use_count_in;
   logic                            freed_in;

   logic                            hit, free_any, frame_we;
   logic [rcsp_pkg::SLOT_BITS-1:0]  hit_idx, free_idx, sel_idx;
   logic [rcsp_pkg::COUNT_BITS-1:0] sel_count, sel_dec, lat_dec;
   logic [rcsp_pkg::FRAME_BITS-1:0] sel_frame;

   // tag compare against the incoming frame, registered at accept
   always_comb begin
      for (int i = 0; i < rcsp_pkg::SLOTS; i++) begin
         match_in[i] = busy_ff[i] && (frame_ff[i] == req_frame_index);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_op;
         fr_ff        <= req_frame_index;
         match_ff     <= match_in;
         lat_count_ff <= count_ff[latest_slot_ff];
      end
   end

   // lowest matching slot and lowest free slot
   always_comb begin
      hit      = |match_ff;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = rcsp_pkg::SLOTS - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_idx = rcsp_pkg::SLOT_BITS'(i);
         if (!busy_ff[i]) begin
            free_idx = rcsp_pkg::SLOT_BITS'(i);
            free_any = 1'b1;
         end
      end
   end

   assign sel_idx   = (op_ff == rcsp_pkg::OP_ACQUIRE_LATEST) ? latest_slot_ff : hit_idx;
   assign sel_count = count_ff[sel_idx];
   assign sel_frame = frame_ff[sel_idx];
   assign sel_dec   = (sel_count == '0) ? '0 : sel_count - 1'b1;
   assign lat_dec   = (lat_count_ff == '0) ? '0 : lat_count_ff - 1'b1;

   always_comb begin
      busy_in         = busy_ff;
      count_in        = count_ff;
      frame_we        = 1'b0;
      latest_valid_in = latest_valid_ff;
      latest_slot_in  = latest_slot_ff;
      status_in       = rcsp_pkg::ST_NOT_FOUND;
      slot_in         = '0;
      frame_out_in    = fr_ff;
      use_count_in    = '0;
      freed_in        = 1'b0;

      unique case (op_ff)
         rcsp_pkg::OP_NEW: begin
            if (hit) begin
               status_in    = rcsp_pkg::ST_DUPLICATE;
               slot_in      = hit_idx;
               use_count_in = sel_count;
            end else if (!free_any) begin
               status_in = rcsp_pkg::ST_FULL;
            end else begin
               busy_in[free_idx]  = 1'b1;
               count_in[free_idx] = rcsp_pkg::COUNT_BITS'(1);
               frame_we           = 1'b1;
               status_in          = rcsp_pkg::ST_OK;
               slot_in            = free_idx;
               use_count_in       = rcsp_pkg::COUNT_BITS'(1);
            end
         end

         rcsp_pkg::OP_ACQUIRE, rcsp_pkg::OP_ACQUIRE_LATEST: begin
            if (op_ff == rcsp_pkg::OP_ACQUIRE && !hit) begin
               status_in = rcsp_pkg::ST_NOT_FOUND;
            end else if (op_ff == rcsp_pkg::OP_ACQUIRE_LATEST && !latest_valid_ff) begin
               status_in = rcsp_pkg::ST_NO_LATEST;
            end else if (sel_count == rcsp_pkg::COUNT_MAX) begin
               status_in    = rcsp_pkg::ST_OVERFLOW;
               slot_in      = sel_idx;
               frame_out_in = sel_frame;
               use_count_in = sel_count;
            end else begin
               count_in[sel_idx] = sel_count + 1'b1;
               status_in         = rcsp_pkg::ST_OK;
               slot_in           = sel_idx;
               frame_out_in      = sel_frame;
               use_count_in      = sel_count + 1'b1;
            end
         end

         rcsp_pkg::OP_SET_LATEST: begin
            if (latest_valid_ff && match_ff[latest_slot_ff]) begin
               // already the latest frame: no change
               status_in    = rcsp_pkg::ST_OK;
               slot_in      = latest_slot_ff;
               use_count_in = lat_count_ff;
            end else begin
               latest_valid_in = 1'b0;
               // drop the pool's hold on the old latest; never the hit slot
               if (latest_valid_ff) begin
                  count_in[latest_slot_ff] = lat_dec;
                  if (lat_dec == '0) begin
                     busy_in[latest_slot_ff] = 1'b0;
                     freed_in                = 1'b1;
                  end
               end
               if (!hit) begin
                  status_in = rcsp_pkg::ST_NOT_FOUND;
               end else if (sel_count == rcsp_pkg::COUNT_MAX) begin
                  status_in    = rcsp_pkg::ST_OVERFLOW;
                  slot_in      = hit_idx;
                  use_count_in = sel_count;
               end else begin
                  count_in[hit_idx] = sel_count + 1'b1;
                  latest_valid_in   = 1'b1;
                  latest_slot_in    = hit_idx;
                  status_in         = rcsp_pkg::ST_OK;
                  slot_in           = hit_idx;
                  use_count_in      = sel_count + 1'b1;
               end
            end
         end

         rcsp_pkg::OP_RELEASE: begin
            if (hit) begin
               count_in[hit_idx] = sel_dec;
               if (sel_dec == '0) begin
                  busy_in[hit_idx] = 1'b0;
                  freed_in         = 1'b1;
                  if (latest_valid_ff && latest_slot_ff == hit_idx) latest_valid_in = 1'b0;
               end
               status_in    = rcsp_pkg::ST_OK;
               slot_in      = hit_idx;
               use_count_in = sel_dec;
            end
         end

         default: begin
            status_in = rcsp_pkg::ST_NOT_FOUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= '0;
         latest_valid_ff <= 1'b0;
         latest_slot_ff  <= '0;
         for (int i = 0; i < rcsp_pkg::SLOTS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (cmd.exec) begin
         busy_ff         <= busy_in;
         latest_valid_ff <= latest_valid_in;
         latest_slot_ff  <= latest_slot_in;
         count_ff        <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && frame_we) begin
         frame_ff[free_idx] <= fr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff    <= status_in;
         slot_ff      <= slot_in;
         frame_out_ff <= frame_out_in;
         use_count_ff <= use_count_in;
         freed_ff     <= freed_in;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_slot       = slot_ff;
   assign rsp_frame_out  = frame_out_ff;
   assign rsp_use_count  = use_count_ff;
   assign rsp_slot_freed = freed_ff;

endmodule

FILE: sv/refcounted_slot_pool_top.sv
// ----------------------------------------------------------------------------
// refcounted_slot_pool_top
// Pool of 16 frame slots with use counts and a latest-frame hold.
//
//   channel  dir  handshake        payload
//   req_ch   in   valid / ready    op, frame_index
//   rsp_ch   out  valid / ready    status, slot, frame_out, use_count, slot_freed
//
// For each request, the accept cycle registers the 16-way tag compare, and
// the next cycle updates the slot tables and loads the response.
// A new request is accepted in the cycle its predecessor's response is taken.
// Synchronous reset clears busy bits, counts and latest.
// A stalled response (rsp_ch.ready low) holds its payload and blocks requests.
// ----------------------------------------------------------------------------
module refcounted_slot_pool_top (
   input logic        clock,
   input logic        reset,
   rcsp_req_if.sink   req_ch,
   rcsp_rsp_if.source rsp_ch
);

   rcsp_pkg::cmd_type cmd;

   rcsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   rcsp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_ch.op),
      .req_frame_index (req_ch.frame_index),
      .rsp_status      (rsp_ch.status),
      .rsp_slot        (rsp_ch.slot),
      .rsp_frame_out   (rsp_ch.frame_out),
      .rsp_use_count   (rsp_ch.use_count),
      .rsp_slot_freed  (rsp_ch.slot_freed)
   );

endmodule

FILE: sv/rcsp_checker.sv
// ----------------------------------------------------------------------------
// rcsp_checker
// Port-level checks on the slot pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcsp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [rcsp_pkg::ST_BITS-1:0]     rsp_status,
   input logic [rcsp_pkg::SLOT_BITS-1:0]   rsp_slot,
   input logic [rcsp_pkg::FRAME_BITS-1:0]  rsp_frame_out,
   input logic [rcsp_pkg::COUNT_BITS-1:0]  rsp_use_count,
   input logic                             rsp_slot_freed
);

   `RCSP_ASSERT_SYNC(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   `RCSP_ASSERT_SYNC(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_frame_out) && $stable(rsp_use_count) && $stable(rsp_slot_freed), "response payload changed while stalled")

   `RCSP_ASSERT_SYNC(a_req_to_rsp, clock, reset, req_valid && req_ready |=> !req_ready ##1 rsp_valid, "request did not produce a response two cycles later")

   `RCSP_ASSERT_SYNC(a_not_found_empty, clock, reset, rsp_valid && rsp_status == rcsp_pkg::ST_NOT_FOUND |-> rsp_slot == '0 && rsp_use_count == '0, "not-found response reports a slot or count")

   `RCSP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "response pending right after reset")

endmodule

bind refcounted_slot_pool_top rcsp_checker u_rcsp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_slot       (rsp_ch.slot),
   .rsp_frame_out  (rsp_ch.frame_out),
   .rsp_use_count  (rsp_ch.use_count),
   .rsp_slot_freed (rsp_ch.slot_freed)
);
